>>> hdl/adsr_pkg.sv
// ----------------------------------------------------------------------------
// adsr_pkg
// Shared types for the linear ADSR envelope pipeline: register indexes,
// envelope phase codes and the per-request control bundle.
// ----------------------------------------------------------------------------
package adsr_pkg;

    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ATTACK  = 3'd0,
        CFG_DECAY   = 3'd1,
        CFG_RELEASE = 3'd2,
        CFG_START   = 3'd3,
        CFG_SUSTAIN = 3'd4
    } cfg_idx_t;

    typedef enum logic [1:0] {
        PH_PEAK,
        PH_ATTACK,
        PH_DECAY,
        PH_SUSTAIN
    } phase_t;

    typedef struct packed {
        logic   held;
        logic   early;
        logic   fwd;
        phase_t phase;
    } env_ctl_t;

    localparam int ENV_CTL_W = $bits(env_ctl_t);

endpackage

>>> hdl/adsr_cfg.sv
// ----------------------------------------------------------------------------
// adsr_cfg
// Envelope setting registers: index decode on a plain write port.
// ----------------------------------------------------------------------------
module adsr_cfg #(
    parameter int TICK_BITS  = 32,
    parameter int LEVEL_BITS = 16,
    parameter int DATA_BITS  = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [adsr_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [DATA_BITS-1:0]              cfg_data,
    output logic [TICK_BITS-1:0]              attack_ticks,
    output logic [TICK_BITS-1:0]              decay_ticks,
    output logic [TICK_BITS-1:0]              release_ticks,
    output logic [LEVEL_BITS-1:0]             start_level,
    output logic [LEVEL_BITS-1:0]             sustain_level
);
    import adsr_pkg::*;

    logic [TICK_BITS-1:0]  attack_reg;
    logic [TICK_BITS-1:0]  decay_reg;
    logic [TICK_BITS-1:0]  release_reg;
    logic [LEVEL_BITS-1:0] start_reg;
    logic [LEVEL_BITS-1:0] sustain_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attack_reg  <= TICK_BITS'(32'd4410);
            decay_reg   <= TICK_BITS'(32'd4410);
            release_reg <= TICK_BITS'(32'd8820);
            start_reg   <= LEVEL_BITS'(32'd32768);
            sustain_reg <= LEVEL_BITS'(32'd32768);
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_ATTACK:  attack_reg  <= cfg_data[TICK_BITS-1:0];
                CFG_DECAY:   decay_reg   <= cfg_data[TICK_BITS-1:0];
                CFG_RELEASE: release_reg <= cfg_data[TICK_BITS-1:0];
                CFG_START:   start_reg   <= cfg_data[LEVEL_BITS-1:0];
                CFG_SUSTAIN: sustain_reg <= cfg_data[LEVEL_BITS-1:0];
                default:     ;
            endcase
        end
    end

    assign attack_ticks  = attack_reg;
    assign decay_ticks   = decay_reg;
    assign release_ticks = release_reg;
    assign start_level   = start_reg;
    assign sustain_level = sustain_reg;

endmodule

>>> hdl/adsr_phase.sv
// ----------------------------------------------------------------------------
// adsr_phase
// Three-stage front end: note state and lifetime, attack boundary, decay
// boundary, then operand selection for the held-level ratio.
// ----------------------------------------------------------------------------
module adsr_phase #(
    parameter int TICK_BITS  = 32,
    parameter int LEVEL_BITS = 16
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     en,
    input  logic                     in_valid,
    input  logic [TICK_BITS-1:0]     now_tick,
    input  logic [TICK_BITS-1:0]     on_tick,
    input  logic [TICK_BITS-1:0]     off_tick,
    input  logic [TICK_BITS-1:0]     attack_ticks,
    input  logic [TICK_BITS-1:0]     decay_ticks,
    input  logic [LEVEL_BITS-1:0]    start_level,
    input  logic [LEVEL_BITS-1:0]    sustain_level,
    output logic                     out_valid,
    output adsr_pkg::env_ctl_t       out_ctl,
    output logic [TICK_BITS-1:0]     op_a,
    output logic [LEVEL_BITS-1:0]    op_b,
    output logic [TICK_BITS-1:0]     op_c,
    output logic [TICK_BITS-1:0]     rel_a
);
    import adsr_pkg::*;

    // stage 1: note state, lifetime and release distance
    logic                 s1_held_next;
    logic                 s1_early_next;
    logic                 s1_fwd_next;
    logic [TICK_BITS-1:0] s1_life_next;
    logic [TICK_BITS-1:0] s1_rel_a_next;
    logic                 s1_valid_reg;
    logic                 s1_held_reg;
    logic                 s1_early_reg;
    logic                 s1_fwd_reg;
    logic [TICK_BITS-1:0] s1_life_reg;
    logic [TICK_BITS-1:0] s1_rel_a_reg;

    always_comb
    begin
        s1_held_next  = on_tick > off_tick;
        s1_early_next = s1_held_next && (now_tick < on_tick);
        s1_fwd_next   = now_tick >= off_tick;
        s1_life_next  = s1_held_next ? (now_tick - on_tick) : (off_tick - on_tick);
        s1_rel_a_next = s1_fwd_next ? (now_tick - off_tick) : (off_tick - now_tick);
    end

    // stage 2: attack boundary
    logic                 s2_in_att_next;
    logic [TICK_BITS-1:0] s2_diff_next;
    logic [LEVEL_BITS-1:0] s2_mag_next;
    logic                 s2_valid_reg;
    logic                 s2_held_reg;
    logic                 s2_early_reg;
    logic                 s2_fwd_reg;
    logic                 s2_in_att_reg;
    logic [TICK_BITS-1:0] s2_life_reg;
    logic [TICK_BITS-1:0] s2_diff_reg;
    logic [TICK_BITS-1:0] s2_rel_a_reg;
    logic [LEVEL_BITS-1:0] s2_mag_reg;

    always_comb
    begin
        s2_in_att_next = s1_life_reg <= attack_ticks;
        s2_diff_next   = s1_life_reg - attack_ticks;
        s2_mag_next    = (sustain_level >= start_level) ? (sustain_level - start_level)
                                                        : (start_level - sustain_level);
    end

    // stage 3: decay boundary and ratio operands
    env_ctl_t              s3_ctl_next;
    logic [TICK_BITS-1:0]  s3_a_next;
    logic [LEVEL_BITS-1:0] s3_b_next;
    logic [TICK_BITS-1:0]  s3_c_next;
    logic                  s3_valid_reg;
    env_ctl_t              s3_ctl_reg;
    logic [TICK_BITS-1:0]  s3_a_reg;
    logic [LEVEL_BITS-1:0] s3_b_reg;
    logic [TICK_BITS-1:0]  s3_c_reg;
    logic [TICK_BITS-1:0]  s3_rel_a_reg;

    always_comb
    begin
        s3_ctl_next.held  = s2_held_reg;
        s3_ctl_next.early = s2_early_reg;
        s3_ctl_next.fwd   = s2_fwd_reg;
        if (s2_in_att_reg)
        begin
            s3_ctl_next.phase = (attack_ticks == '0) ? PH_PEAK : PH_ATTACK;
            s3_a_next         = s2_life_reg;
            s3_b_next         = start_level;
            s3_c_next         = attack_ticks;
        end
        else
        begin
            s3_ctl_next.phase = (s2_diff_reg <= decay_ticks) ? PH_DECAY : PH_SUSTAIN;
            s3_a_next         = s2_diff_reg;
            s3_b_next         = s2_mag_reg;
            s3_c_next         = decay_ticks;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_held_reg   <= s1_held_next;
            s1_early_reg  <= s1_early_next;
            s1_fwd_reg    <= s1_fwd_next;
            s1_life_reg   <= s1_life_next;
            s1_rel_a_reg  <= s1_rel_a_next;
            s2_held_reg   <= s1_held_reg;
            s2_early_reg  <= s1_early_reg;
            s2_fwd_reg    <= s1_fwd_reg;
            s2_in_att_reg <= s2_in_att_next;
            s2_life_reg   <= s1_life_reg;
            s2_diff_reg   <= s2_diff_next;
            s2_rel_a_reg  <= s1_rel_a_reg;
            s2_mag_reg    <= s2_mag_next;
            s3_ctl_reg    <= s3_ctl_next;
            s3_a_reg      <= s3_a_next;
            s3_b_reg      <= s3_b_next;
            s3_c_reg      <= s3_c_next;
            s3_rel_a_reg  <= s2_rel_a_reg;
        end
    end

    assign out_valid = s3_valid_reg;
    assign out_ctl   = s3_ctl_reg;
    assign op_a      = s3_a_reg;
    assign op_b      = s3_b_reg;
    assign op_c      = s3_c_reg;
    assign rel_a     = s3_rel_a_reg;

endmodule

>>> hdl/adsr_muldiv.sv
// ----------------------------------------------------------------------------
// adsr_muldiv
// Pipelined floor(a * b / c), saturated at all ones of the level width.
// Two-part product, overflow check, then one restoring quotient bit a stage.
// ----------------------------------------------------------------------------
module adsr_muldiv #(
    parameter int TICK_BITS  = 32,
    parameter int LEVEL_BITS = 16,
    parameter int SIDE_BITS  = 8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  in_valid,
    input  logic [TICK_BITS-1:0]  op_a,
    input  logic [LEVEL_BITS-1:0] op_b,
    input  logic [TICK_BITS-1:0]  op_c,
    input  logic [SIDE_BITS-1:0]  in_side,
    output logic                  out_valid,
    output logic [LEVEL_BITS-1:0] quot,
    output logic [SIDE_BITS-1:0]  out_side
);
    localparam int LO_BITS   = TICK_BITS / 2;
    localparam int HI_BITS   = TICK_BITS - LO_BITS;
    localparam int PROD_BITS = TICK_BITS + LEVEL_BITS;

    // product, split in halves of the tick operand
    logic [LO_BITS+LEVEL_BITS-1:0] pp_lo_next;
    logic [HI_BITS+LEVEL_BITS-1:0] pp_hi_next;
    logic                          m1_valid_reg;
    logic [LO_BITS+LEVEL_BITS-1:0] pp_lo_reg;
    logic [HI_BITS+LEVEL_BITS-1:0] pp_hi_reg;
    logic [TICK_BITS-1:0]          m1_c_reg;
    logic [SIDE_BITS-1:0]          m1_side_reg;

    assign pp_lo_next = {{LEVEL_BITS{1'b0}}, op_a[LO_BITS-1:0]}
                      * {{LO_BITS{1'b0}}, op_b};
    assign pp_hi_next = {{LEVEL_BITS{1'b0}}, op_a[TICK_BITS-1:LO_BITS]}
                      * {{HI_BITS{1'b0}}, op_b};

    logic [PROD_BITS-1:0] prod_next;
    logic                 m2_valid_reg;
    logic [PROD_BITS-1:0] prod_reg;
    logic [TICK_BITS-1:0] m2_c_reg;
    logic [SIDE_BITS-1:0] m2_side_reg;

    assign prod_next = {{HI_BITS{1'b0}}, pp_lo_reg} + {pp_hi_reg, {LO_BITS{1'b0}}};

    // quotient stages; stage 0 holds the upper product and the overflow flag
    logic                  vld_reg  [LEVEL_BITS+1];
    logic [TICK_BITS-1:0]  rem_reg  [LEVEL_BITS+1];
    logic [LEVEL_BITS-1:0] dvd_reg  [LEVEL_BITS+1];
    logic [TICK_BITS-1:0]  dsr_reg  [LEVEL_BITS+1];
    logic                  sat_reg  [LEVEL_BITS+1];
    logic [SIDE_BITS-1:0]  side_reg [LEVEL_BITS+1];

    logic sat_next;

    assign sat_next = prod_reg[PROD_BITS-1:LEVEL_BITS] >= m2_c_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m1_valid_reg <= 1'b0;
            m2_valid_reg <= 1'b0;
            vld_reg[0]   <= 1'b0;
        end
        else if (en)
        begin
            m1_valid_reg <= in_valid;
            m2_valid_reg <= m1_valid_reg;
            vld_reg[0]   <= m2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pp_lo_reg   <= pp_lo_next;
            pp_hi_reg   <= pp_hi_next;
            m1_c_reg    <= op_c;
            m1_side_reg <= in_side;
            prod_reg    <= prod_next;
            m2_c_reg    <= m1_c_reg;
            m2_side_reg <= m1_side_reg;
            rem_reg[0]  <= prod_reg[PROD_BITS-1:LEVEL_BITS];
            dvd_reg[0]  <= prod_reg[LEVEL_BITS-1:0];
            dsr_reg[0]  <= m2_c_reg;
            sat_reg[0]  <= sat_next;
            side_reg[0] <= m2_side_reg;
        end
    end

    genvar k;
    generate
        for (k = 0; k < LEVEL_BITS; k++)
        begin : g_step
            logic [TICK_BITS:0]    rem_sh;
            logic [TICK_BITS:0]    rem_sub;
            logic                  take;
            logic [TICK_BITS-1:0]  rem_next;
            logic [LEVEL_BITS-1:0] dvd_next;

            assign rem_sh   = {rem_reg[k], dvd_reg[k][LEVEL_BITS-1]};
            assign rem_sub  = rem_sh - {1'b0, dsr_reg[k]};
            assign take     = rem_sh >= {1'b0, dsr_reg[k]};
            assign rem_next = take ? rem_sub[TICK_BITS-1:0] : rem_sh[TICK_BITS-1:0];
            assign dvd_next = {dvd_reg[k][LEVEL_BITS-2:0], take};

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    vld_reg[k+1] <= 1'b0;
                end
                else if (en)
                begin
                    vld_reg[k+1] <= vld_reg[k];
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k+1]  <= rem_next;
                    dvd_reg[k+1]  <= dvd_next;
                    dsr_reg[k+1]  <= dsr_reg[k];
                    sat_reg[k+1]  <= sat_reg[k];
                    side_reg[k+1] <= side_reg[k];
                end
            end
        end
    endgenerate

    assign out_valid = vld_reg[LEVEL_BITS];
    assign quot      = sat_reg[LEVEL_BITS] ? {LEVEL_BITS{1'b1}} : dvd_reg[LEVEL_BITS];
    assign out_side  = side_reg[LEVEL_BITS];

    // remainder of the last stage is never needed
    logic unused_rem;
    assign unused_rem = ^rem_reg[LEVEL_BITS];

endmodule

>>> hdl/adsr_shape.sv
// ----------------------------------------------------------------------------
// adsr_shape
// Turns the held-phase ratio into the held envelope level, clamped to
// full scale; one register stage.
// ----------------------------------------------------------------------------
module adsr_shape #(
    parameter int TICK_BITS  = 32,
    parameter int LEVEL_BITS = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  in_valid,
    input  adsr_pkg::env_ctl_t    in_ctl,
    input  logic [TICK_BITS-1:0]  in_rel_a,
    input  logic [LEVEL_BITS-1:0] ratio,
    input  logic [LEVEL_BITS-1:0] start_level,
    input  logic [LEVEL_BITS-1:0] sustain_level,
    output logic                  out_valid,
    output adsr_pkg::env_ctl_t    out_ctl,
    output logic [TICK_BITS-1:0]  out_rel_a,
    output logic [LEVEL_BITS-1:0] held_level
);
    import adsr_pkg::*;

    localparam logic [LEVEL_BITS-1:0] FULL_SCALE = {1'b1, {(LEVEL_BITS-1){1'b0}}};

    function automatic logic [LEVEL_BITS-1:0] clamp_full(input logic [LEVEL_BITS-1:0] v);
        clamp_full = (v > FULL_SCALE) ? FULL_SCALE : v;
    endfunction

    logic [LEVEL_BITS:0]   up_sum;
    logic [LEVEL_BITS-1:0] level_next;
    logic                  valid_reg;
    env_ctl_t              ctl_reg;
    logic [TICK_BITS-1:0]  rel_a_reg;
    logic [LEVEL_BITS-1:0] level_reg;

    assign up_sum = {1'b0, start_level} + {1'b0, ratio};

    always_comb
    begin
        case (in_ctl.phase)
            PH_PEAK:    level_next = clamp_full(start_level);
            PH_ATTACK:  level_next = clamp_full(ratio);
            PH_DECAY:
            begin
                if (sustain_level >= start_level)
                    level_next = (up_sum > {1'b0, FULL_SCALE}) ? FULL_SCALE
                                                               : up_sum[LEVEL_BITS-1:0];
                else if (ratio >= start_level)
                    level_next = '0;
                else
                    level_next = clamp_full(start_level - ratio);
            end
            PH_SUSTAIN: level_next = clamp_full(sustain_level);
            default:    level_next = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ctl_reg   <= in_ctl;
            rel_a_reg <= in_rel_a;
            level_reg <= level_next;
        end
    end

    assign out_valid  = valid_reg;
    assign out_ctl    = ctl_reg;
    assign out_rel_a  = rel_a_reg;
    assign held_level = level_reg;

endmodule

>>> hdl/adsr_envelope_amplitude.sv
// ----------------------------------------------------------------------------
// adsr_envelope_amplitude
// Linear ADSR envelope level for one note per request.
//
// Input channel: in_valid / in_stall with now_tick, on_tick, off_tick.
// Output channel: out_valid / out_stall with level, unsigned Q1.LEVEL_FRAC_BITS.
// A request moves on a rising edge with valid high and stall low.
// Settings are written through cfg_we / cfg_index / cfg_data by the user only
// while idle, which the block does not enforce. The pipeline holds three front
// stages, two pipelined multiply-divide units of LEVEL_FRAC_BITS + 4 stages
// each (one quotient bit a stage), one shaping stage and the output register.
// One request is taken every cycle while the output is not stalled. When
// out_stall holds a result, the pipeline keeps advancing until its last stage
// is occupied; only then does in_stall rise, and nothing is dropped.
// Reset empties the pipeline and loads the default envelope settings.
// ----------------------------------------------------------------------------
module adsr_envelope_amplitude #(
    parameter int TICK_BITS       = 32,
    parameter int LEVEL_FRAC_BITS = 15
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [TICK_BITS-1:0]                now_tick,
    input  logic [TICK_BITS-1:0]                on_tick,
    input  logic [TICK_BITS-1:0]                off_tick,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [LEVEL_FRAC_BITS:0]            level,
    input  logic                                cfg_we,
    input  logic [adsr_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [(TICK_BITS > LEVEL_FRAC_BITS + 1 ? TICK_BITS
                   : LEVEL_FRAC_BITS + 1) - 1:0] cfg_data
);
    import adsr_pkg::*;

    localparam int LEVEL_BITS = LEVEL_FRAC_BITS + 1;
    localparam int DATA_BITS  = (TICK_BITS > LEVEL_BITS) ? TICK_BITS : LEVEL_BITS;
    localparam int SIDE1_BITS = ENV_CTL_W + TICK_BITS;
    localparam int SIDE2_BITS = ENV_CTL_W + LEVEL_BITS;
    localparam logic [LEVEL_BITS-1:0] FULL_SCALE = {1'b1, {LEVEL_FRAC_BITS{1'b0}}};

    logic [TICK_BITS-1:0]  attack_ticks;
    logic [TICK_BITS-1:0]  decay_ticks;
    logic [TICK_BITS-1:0]  release_ticks;
    logic [LEVEL_BITS-1:0] start_level;
    logic [LEVEL_BITS-1:0] sustain_level;

    logic en;
    logic out_load;
    logic last_valid;

    adsr_cfg #(
        .TICK_BITS  (TICK_BITS),
        .LEVEL_BITS (LEVEL_BITS),
        .DATA_BITS  (DATA_BITS)
    ) u_cfg (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .attack_ticks  (attack_ticks),
        .decay_ticks   (decay_ticks),
        .release_ticks (release_ticks),
        .start_level   (start_level),
        .sustain_level (sustain_level)
    );

    // front end
    logic                  ph_valid;
    env_ctl_t              ph_ctl;
    logic [TICK_BITS-1:0]  ph_a;
    logic [LEVEL_BITS-1:0] ph_b;
    logic [TICK_BITS-1:0]  ph_c;
    logic [TICK_BITS-1:0]  ph_rel_a;

    adsr_phase #(
        .TICK_BITS  (TICK_BITS),
        .LEVEL_BITS (LEVEL_BITS)
    ) u_phase (
        .clk           (clk),
        .rst_n         (rst_n),
        .en            (en),
        .in_valid      (in_valid),
        .now_tick      (now_tick),
        .on_tick       (on_tick),
        .off_tick      (off_tick),
        .attack_ticks  (attack_ticks),
        .decay_ticks   (decay_ticks),
        .start_level   (start_level),
        .sustain_level (sustain_level),
        .out_valid     (ph_valid),
        .out_ctl       (ph_ctl),
        .op_a          (ph_a),
        .op_b          (ph_b),
        .op_c          (ph_c),
        .rel_a         (ph_rel_a)
    );

    // held-phase ratio
    logic                  md1_valid;
    logic [LEVEL_BITS-1:0] md1_q;
    logic [SIDE1_BITS-1:0] md1_side;

    adsr_muldiv #(
        .TICK_BITS  (TICK_BITS),
        .LEVEL_BITS (LEVEL_BITS),
        .SIDE_BITS  (SIDE1_BITS)
    ) u_held_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (ph_valid),
        .op_a      (ph_a),
        .op_b      (ph_b),
        .op_c      (ph_c),
        .in_side   ({ph_ctl, ph_rel_a}),
        .out_valid (md1_valid),
        .quot      (md1_q),
        .out_side  (md1_side)
    );

    env_ctl_t              md1_ctl;
    logic [TICK_BITS-1:0]  md1_rel_a;

    assign md1_ctl   = env_ctl_t'(md1_side[SIDE1_BITS-1:TICK_BITS]);
    assign md1_rel_a = md1_side[TICK_BITS-1:0];

    logic                  sh_valid;
    env_ctl_t              sh_ctl;
    logic [TICK_BITS-1:0]  sh_rel_a;
    logic [LEVEL_BITS-1:0] sh_level;

    adsr_shape #(
        .TICK_BITS  (TICK_BITS),
        .LEVEL_BITS (LEVEL_BITS)
    ) u_shape (
        .clk           (clk),
        .rst_n         (rst_n),
        .en            (en),
        .in_valid      (md1_valid),
        .in_ctl        (md1_ctl),
        .in_rel_a      (md1_rel_a),
        .ratio         (md1_q),
        .start_level   (start_level),
        .sustain_level (sustain_level),
        .out_valid     (sh_valid),
        .out_ctl       (sh_ctl),
        .out_rel_a     (sh_rel_a),
        .held_level    (sh_level)
    );

    // release ramp ratio
    logic [LEVEL_BITS-1:0] md2_q;
    logic [SIDE2_BITS-1:0] md2_side;

    adsr_muldiv #(
        .TICK_BITS  (TICK_BITS),
        .LEVEL_BITS (LEVEL_BITS),
        .SIDE_BITS  (SIDE2_BITS)
    ) u_release_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (sh_valid),
        .op_a      (sh_rel_a),
        .op_b      (sh_level),
        .op_c      (release_ticks),
        .in_side   ({sh_ctl, sh_level}),
        .out_valid (last_valid),
        .quot      (md2_q),
        .out_side  (md2_side)
    );

    env_ctl_t              fin_ctl;
    logic [LEVEL_BITS-1:0] fin_held;
    logic [LEVEL_BITS-1:0] fwd_level;
    logic [LEVEL_BITS:0]   back_sum;
    logic [LEVEL_BITS-1:0] back_level;
    logic [LEVEL_BITS-1:0] level_next;

    assign fin_ctl  = env_ctl_t'(md2_side[SIDE2_BITS-1:LEVEL_BITS]);
    assign fin_held = md2_side[LEVEL_BITS-1:0];
    assign back_sum = {1'b0, fin_held} + {1'b0, md2_q};

    always_comb
    begin
        fwd_level  = (md2_q >= fin_held) ? '0 : (fin_held - md2_q);
        back_level = (back_sum > {1'b0, FULL_SCALE}) ? FULL_SCALE
                                                     : back_sum[LEVEL_BITS-1:0];
        if (fin_ctl.held)
            level_next = fin_ctl.early ? '0 : fin_held;
        else if (release_ticks == '0)
            level_next = '0;
        else
            level_next = fin_ctl.fwd ? fwd_level : back_level;
    end

    // output register and pipeline advance
    logic                  out_valid_reg;
    logic [LEVEL_BITS-1:0] level_reg;

    assign out_load = !out_valid_reg || !out_stall;
    assign en       = out_load || !last_valid;
    assign in_stall = !en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= last_valid;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
            level_reg <= level_next;
    end

    assign out_valid = out_valid_reg;
    assign level     = level_reg;

    // a new result only comes from an occupied last stage
    a_out_from_pipe : assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(last_valid))
        else $error("result appeared without a finished request");

    // a frozen pipeline keeps its last request
    a_hold_last : assert property (@(posedge clk) disable iff (!rst_n)
        (last_valid && in_stall) |=> last_valid)
        else $error("request lost while pipeline stalled");

    // output drains when nothing follows
    a_drain : assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_stall && !last_valid) |=> !out_valid_reg)
        else $error("result repeated");

    // level never above full scale
    a_range : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (level_reg <= FULL_SCALE))
        else $error("level above full scale");

endmodule
